// ===== hw/rtl/wrs_pkg.sv =====
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared types and codes of the weighted runtime min scheduler.
// ----------------------------------------------------------------------------
package wrs_pkg;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_SET_RT = 2'd2,
        MODE_PICK   = 2'd3
    } t_mode;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 16;

    typedef struct packed {
        logic en_all;
        logic en_rt;
    } t_wr_ctl;

endpackage

// ===== hw/rtl/wrs_queue_mem.sv =====
// ----------------------------------------------------------------------------
// wrs_queue_mem
// Run queue storage: id, class and runtime memories, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module wrs_queue_mem #(
    parameter int MAX_ENTRIES  = 16,
    parameter int ID_BITS      = 8,
    parameter int RUNTIME_BITS = 48,
    localparam int ADDR_W      = $clog2(MAX_ENTRIES)
) (
    input  logic                    i_clk,
    input  wrs_pkg::t_wr_ctl        i_wr,
    input  logic [ADDR_W-1:0]       i_waddr,
    input  logic [ID_BITS-1:0]      i_wid,
    input  logic [1:0]              i_wcls,
    input  logic [RUNTIME_BITS-1:0] i_wrt,
    input  logic [ADDR_W-1:0]       i_raddr,
    output logic [ID_BITS-1:0]      o_rid,
    output logic [1:0]              o_rcls,
    output logic [RUNTIME_BITS-1:0] o_rrt
);
    import wrs_pkg::*;

    logic [ID_BITS-1:0]      r_ids      [MAX_ENTRIES];
    logic [1:0]              r_classes  [MAX_ENTRIES];
    logic [RUNTIME_BITS-1:0] r_runtimes [MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr.en_all) begin
            r_ids[i_waddr]     <= i_wid;
            r_classes[i_waddr] <= i_wcls;
        end
        if (i_wr.en_all || i_wr.en_rt) begin
            r_runtimes[i_waddr] <= i_wrt;
        end
        o_rid  <= r_ids[i_raddr];
        o_rcls <= r_classes[i_raddr];
        o_rrt  <= r_runtimes[i_raddr];
    end

endmodule

// ===== hw/rtl/wrs_weight.sv =====
// ----------------------------------------------------------------------------
// wrs_weight
// Registered class weighting: runtime times 1, 2, 3 or 4 by shift and add.
// ----------------------------------------------------------------------------
module wrs_weight #(
    parameter int ID_BITS      = 8,
    parameter int RUNTIME_BITS = 48,
    localparam int WT_W        = RUNTIME_BITS + 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic [RUNTIME_BITS-1:0] i_rt,
    input  logic [1:0]              i_cls,
    input  logic [ID_BITS-1:0]      i_id,
    output logic                    o_vld,
    output logic [WT_W-1:0]         o_w,
    output logic [ID_BITS-1:0]      o_id
);
    import wrs_pkg::*;

    logic [WT_W-1:0] rt_ext;
    logic [WT_W-1:0] n_w;

    assign rt_ext = WT_W'(i_rt);

    always_comb begin
        case (i_cls)
            2'd0:    n_w = rt_ext;
            2'd1:    n_w = rt_ext << 1;
            2'd2:    n_w = rt_ext + (rt_ext << 1);
            default: n_w = rt_ext << 2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_w  <= n_w;
        o_id <= i_id;
    end

endmodule

// ===== hw/rtl/weighted_runtime_min_scheduler.sv =====
// Sequence: add writes the entry when accepted unless the queue is full; set
// runtime and pick scan the queue; remove scans, then moves each later entry
// down one slot, one entry per cycle.
// Throughput: one item at a time; the single memory read port walks the queue
// one entry per cycle. A new item is taken while the last result waits.
// Reset (synchronous, active low) empties the queue; stored entries are not
// cleared.
// ----------------------------------------------------------------------------
// weighted_runtime_min_scheduler
// Ordered run queue with add, remove, set runtime and min weighted runtime
// pick, sequenced over a shared memory port and one weight/compare unit.
// ----------------------------------------------------------------------------
module weighted_runtime_min_scheduler #(
    parameter int MAX_ENTRIES  = 16,
    parameter int ID_BITS      = 8,
    parameter int RUNTIME_BITS = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // entity_id[7:0], priority_class[9:8], runtime_value[57:10], zero[63:58]
    input  logic [wrs_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]                      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // status[1:0], picked_valid[2], picked_id[10:3], queue_count[15:11]
    output logic [wrs_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import wrs_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int WT_W   = RUNTIME_BITS + 2;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_ptr, n_ptr;
    t_mode                   r_mode, n_mode;
    logic [ID_BITS-1:0]      r_id, n_id;
    logic [RUNTIME_BITS-1:0] r_rt, n_rt;
    logic                    r_d1_vld, n_d1_vld;
    logic [ADDR_W-1:0]       r_d1_addr, n_d1_addr;
    logic                    r_have, n_have;
    logic [WT_W-1:0]         r_best, n_best;
    logic [ID_BITS-1:0]      r_best_id, n_best_id;
    logic                    r_hit, n_hit;
    logic [1:0]              r_status, n_status;
    logic                    r_pvld, n_pvld;
    logic [ID_BITS-1:0]      r_pid, n_pid;
    logic                    r_m_vld, n_m_vld;
    logic [OUT_TDATA_W-1:0]  r_m_data, n_m_data;

    logic [ID_BITS-1:0]      in_id;
    logic [1:0]              in_cls;
    logic [RUNTIME_BITS-1:0] in_rt;
    logic                    s_xfer;
    logic                    issue;
    logic                    id_match;

    t_wr_ctl                 wr;
    logic [ADDR_W-1:0]       waddr;
    logic [ID_BITS-1:0]      wid;
    logic [1:0]              wcls;
    logic [RUNTIME_BITS-1:0] wrt;

    logic [ID_BITS-1:0]      rd_id;
    logic [1:0]              rd_cls;
    logic [RUNTIME_BITS-1:0] rd_rt;
    logic                    w_vld;
    logic [WT_W-1:0]         w_val;
    logic [ID_BITS-1:0]      w_id;

    logic [31:0]             cnt_ext;
    logic [15:0]             pid_ext;

    assign in_id  = ID_BITS'(16'(i_s_axis_tdata[7:0]));
    assign in_cls = i_s_axis_tdata[9:8];
    assign in_rt  = RUNTIME_BITS'(64'(i_s_axis_tdata[57:10]));

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_m_vld;
    assign o_m_axis_tdata  = r_m_data;

    assign issue    = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_ptr < r_count);
    assign id_match = r_d1_vld && (rd_id == r_id);
    assign cnt_ext  = 32'(r_count);
    assign pid_ext  = 16'(r_pid);

    wrs_queue_mem #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .ID_BITS      (ID_BITS),
        .RUNTIME_BITS (RUNTIME_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_waddr (waddr),
        .i_wid   (wid),
        .i_wcls  (wcls),
        .i_wrt   (wrt),
        .i_raddr (r_ptr[ADDR_W-1:0]),
        .o_rid   (rd_id),
        .o_rcls  (rd_cls),
        .o_rrt   (rd_rt)
    );

    wrs_weight #(
        .ID_BITS      (ID_BITS),
        .RUNTIME_BITS (RUNTIME_BITS)
    ) u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_d1_vld && (r_state == S_SCAN) && (r_mode == MODE_PICK)),
        .i_rt    (rd_rt),
        .i_cls   (rd_cls),
        .i_id    (rd_id),
        .o_vld   (w_vld),
        .o_w     (w_val),
        .o_id    (w_id)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_mode    = r_mode;
        n_id      = r_id;
        n_rt      = r_rt;
        n_d1_vld  = issue;
        n_d1_addr = r_ptr[ADDR_W-1:0];
        n_have    = r_have;
        n_best    = r_best;
        n_best_id = r_best_id;
        n_hit     = r_hit;
        n_status  = r_status;
        n_pvld    = r_pvld;
        n_pid     = r_pid;
        n_m_vld   = r_m_vld && !i_m_axis_tready;
        n_m_data  = r_m_data;
        wr        = '0;
        waddr     = r_count[ADDR_W-1:0];
        wid       = in_id;
        wcls      = in_cls;
        wrt       = in_rt;

        if (issue) begin
            n_ptr = r_ptr + CNT_W'(1);
        end

        if (w_vld && (!r_have || (w_val < r_best))) begin
            n_have    = 1'b1;
            n_best    = w_val;
            n_best_id = w_id;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    n_mode    = t_mode'(i_s_axis_tuser);
                    n_id      = in_id;
                    n_rt      = in_rt;
                    n_ptr     = '0;
                    n_have    = 1'b0;
                    n_best_id = '0;
                    n_hit     = 1'b0;
                    n_status  = ST_OK;
                    n_pvld    = 1'b0;
                    n_pid     = '0;
                    if (t_mode'(i_s_axis_tuser) == MODE_ADD) begin
                        n_state = S_DONE;
                        if (r_count == CNT_MAX) begin
                            n_status = ST_FULL;
                        end else begin
                            wr.en_all = 1'b1;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_mode == MODE_REMOVE && id_match) begin
                    n_state  = S_SHIFT;
                    n_ptr    = CNT_W'(r_d1_addr) + CNT_W'(1);
                    n_d1_vld = 1'b0;
                end else if (r_mode == MODE_SET_RT && id_match) begin
                    wr.en_rt = 1'b1;
                    waddr    = r_d1_addr;
                    wrt      = r_rt;
                    n_hit    = 1'b1;
                end
                if (!issue && !r_d1_vld && !w_vld) begin
                    n_state = S_DONE;
                    case (r_mode)
                        MODE_PICK: begin
                            n_pvld = r_have;
                            n_pid  = r_have ? r_best_id : '0;
                        end
                        MODE_SET_RT: n_status = r_hit ? ST_OK : ST_NOT_FOUND;
                        default:     n_status = ST_NOT_FOUND;
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_d1_vld) begin
                    wr.en_all = 1'b1;
                    waddr     = r_d1_addr - ADDR_W'(1);
                    wid       = rd_id;
                    wcls      = rd_cls;
                    wrt       = rd_rt;
                end
                if (!issue && !r_d1_vld) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_vld || i_m_axis_tready) begin
                    n_m_vld  = 1'b1;
                    n_m_data = {cnt_ext[4:0], pid_ext[7:0], r_pvld, r_status};
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_d1_vld <= 1'b0;
            r_m_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_d1_vld <= n_d1_vld;
            r_m_vld  <= n_m_vld;
        end
        r_ptr     <= n_ptr;
        r_mode    <= n_mode;
        r_id      <= n_id;
        r_rt      <= n_rt;
        r_d1_addr <= n_d1_addr;
        r_have    <= n_have;
        r_best    <= n_best;
        r_best_id <= n_best_id;
        r_hit     <= n_hit;
        r_status  <= n_status;
        r_pvld    <= n_pvld;
        r_pid     <= n_pid;
        r_m_data  <= n_m_data;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("queue count above capacity");

    a_scan_no_full_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !wr.en_all)
        else $error("entry rewritten during scan");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
        ((r_count == $past(r_count) + CNT_W'(1)) || (r_count == $past(r_count) - CNT_W'(1))))
        else $error("queue count moved by more than one");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> !o_s_axis_tready)
        else $error("ready right after accepting a transfer");
`endif

endmodule

// ===== dv/wrs_sched_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrs_sched_checker
// Watches both stream channels of the scheduler. It predicts the result of
// each accepted input transfer and compares each output transfer with the
// oldest prediction.
// ----------------------------------------------------------------------------
module wrs_sched_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_tvalid,
    input  logic                            i_in_tready,
    // entity_id[7:0], priority_class[9:8], runtime_value[57:10], zero[63:58]
    input  logic [wrs_pkg::IN_TDATA_W-1:0]  i_in_tdata,
    // mode[1:0]
    input  logic [1:0]                      i_in_tuser,
    input  logic                            i_out_tvalid,
    input  logic                            i_out_tready,
    // status[1:0], picked_valid[2], picked_id[10:3], queue_count[15:11]
    input  logic [wrs_pkg::OUT_TDATA_W-1:0] i_out_tdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import wrs_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [4:0] queue_count;
        logic [7:0] picked_id;
        logic       picked_valid;
        logic [1:0] status;
    } t_sched_result;

    logic [7:0]     rq_id  [QDEPTH];
    logic [1:0]     rq_cls [QDEPTH];
    logic [47:0]    rq_rt  [QDEPTH];
    int             rq_len;
    t_sched_result  expected_results[$];
    int             mismatches;

    function automatic logic [49:0] weighted_rt(int slot);
        return 50'(rq_rt[slot]) * 50'(rq_cls[slot]) + 50'(rq_rt[slot]);
    endfunction

    function automatic t_sched_result schedule_step(t_mode mode, logic [7:0] id,
                                                    logic [1:0] cls, logic [47:0] rt);
        t_sched_result r;
        int            hit;
        int            best_slot;
        logic [49:0]   best;
        logic [49:0]   w;
        r = '0;
        case (mode)
            MODE_ADD: begin
                if (rq_len >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    rq_id[rq_len]  = id;
                    rq_cls[rq_len] = cls;
                    rq_rt[rq_len]  = rt;
                    rq_len++;
                end
            end
            MODE_REMOVE: begin
                hit = -1;
                for (int i = 0; i < rq_len; i++) begin
                    if (hit < 0 && rq_id[i] == id) hit = i;
                end
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int i = hit; i < rq_len - 1; i++) begin
                        rq_id[i]  = rq_id[i+1];
                        rq_cls[i] = rq_cls[i+1];
                        rq_rt[i]  = rq_rt[i+1];
                    end
                    rq_len--;
                end
            end
            MODE_SET_RT: begin
                hit = 0;
                for (int i = 0; i < rq_len; i++) begin
                    if (rq_id[i] == id) begin
                        rq_rt[i] = rt;
                        hit++;
                    end
                end
                if (hit == 0) r.status = ST_NOT_FOUND;
            end
            default: begin
                if (rq_len > 0) begin
                    best      = weighted_rt(0);
                    best_slot = 0;
                    for (int i = 1; i < rq_len; i++) begin
                        w = weighted_rt(i);
                        if (w < best) begin
                            best      = w;
                            best_slot = i;
                        end
                    end
                    r.picked_valid = 1'b1;
                    r.picked_id    = rq_id[best_slot];
                end
            end
        endcase
        r.queue_count = 5'(rq_len);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (!i_rst_n) begin
            rq_len = 0;
            expected_results.delete();
        end else begin
            if (i_in_tvalid && i_in_tready) begin
                expected_results.push_back(schedule_step(t_mode'(i_in_tuser),
                    i_in_tdata[7:0], i_in_tdata[9:8], i_in_tdata[57:10]));
            end
            if (i_out_tvalid && i_out_tready) begin
                got = t_sched_result'(i_out_tdata);
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result status=%0d valid=%0d id=%0d count=%0d",
                                 $realtime, got.status, got.picked_valid, got.picked_id,
                                 got.queue_count);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.picked_valid !== want.picked_valid
                        || got.picked_id !== want.picked_id
                        || got.queue_count !== want.queue_count) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $write("%0t: mismatch exp status=%0d valid=%0d id=%0d count=%0d",
                                   $realtime, want.status, want.picked_valid, want.picked_id,
                                   want.queue_count);
                            $display(" got status=%0d valid=%0d id=%0d count=%0d",
                                     got.status, got.picked_valid, got.picked_id,
                                     got.queue_count);
                        end
                    end
                end
            end
        end
        o_pending    = expected_results.size();
        o_fail_count = mismatches;
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random add, remove, set runtime and pick transfers into
// the scheduler with random gaps and output stalls; the checker predicts and
// compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import wrs_pkg::*;

    localparam int RANDOM_ITEMS   = 1925;
    localparam int DRAIN_AT       = 1000;
    localparam int RX_HOLD_AT     = 300;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int IDLE_LIMIT     = 4000;
    localparam int TAIL_CYCLES    = 40;

    logic                   i_clk;
    logic                   i_rst_n    = 1'b0;
    logic                   in_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  in_tdata   = '0;
    logic [1:0]             in_tuser   = '0;
    logic                   out_tready = 1'b0;
    logic                   in_tready;
    logic                   out_tvalid;
    logic [OUT_TDATA_W-1:0] out_tdata;
    wire                    in_fire  = in_tvalid & in_tready;
    wire                    out_fire = out_tvalid & out_tready;
    int                     fail_count;
    int                     pending;
    int                     rx_count   = 0;
    int                     idle_cycles = 0;

    weighted_runtime_min_scheduler i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (in_tvalid),
        .o_s_axis_tready (in_tready),
        .i_s_axis_tdata  (in_tdata),
        .i_s_axis_tuser  (in_tuser),
        .o_m_axis_tvalid (out_tvalid),
        .i_m_axis_tready (out_tready),
        .o_m_axis_tdata  (out_tdata)
    );

    wrs_sched_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (in_tvalid),
        .i_in_tready  (in_tready),
        .i_in_tdata   (in_tdata),
        .i_in_tuser   (in_tuser),
        .i_out_tvalid (out_tvalid),
        .i_out_tready (out_tready),
        .i_out_tdata  (out_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (out_fire) rx_count <= rx_count + 1;
        if (!i_rst_n || in_fire || out_fire) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int next_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 20);
    endfunction

    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            in_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic send_item(t_mode mode, logic [7:0] id, logic [1:0] cls, logic [47:0] rt,
                             bit no_gap);
        @(negedge i_clk);
        in_tvalid <= 1'b1;
        in_tdata  <= {6'b0, rt, cls, id};
        in_tuser  <= mode;
        do @(posedge i_clk); while (!in_fire);
        if (!no_gap) idle_gap(next_gap());
    endtask

    // output side: random stalls, ready-only windows, one long hold-off
    initial begin
        int stall;
        bit held;
        stall = 0;
        held  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && rx_count >= RX_HOLD_AT) begin
                held = 1'b1;
                out_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end else if ((rx_count / 100) % 5 == 1) begin
                out_tready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                out_tready <= 1'b0;
            end else if ($urandom_range(99) < 75) begin
                out_tready <= 1'b1;
            end else begin
                out_tready <= 1'b0;
                stall = ($urandom_range(99) < 90) ? $urandom_range(2) : $urandom_range(60, 20);
            end
        end
    end

    initial begin
        int          bias;
        int          add_pct;
        int          rem_pct;
        int          r;
        t_mode       mode;
        logic [7:0]  id;
        logic [1:0]  cls;
        logic [47:0] rt;

        i_rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue cases
        send_item(MODE_PICK,   8'd0, 2'd0, 48'd0, 1'b0);
        send_item(MODE_REMOVE, 8'd5, 2'd0, 48'd0, 1'b0);
        send_item(MODE_SET_RT, 8'd5, 2'd0, 48'd9, 1'b0);
        // field extremes, duplicate ids, set runtime on every match, ties
        send_item(MODE_ADD,    8'd0,   2'd0, '1,       1'b0);
        send_item(MODE_ADD,    8'd255, 2'd3, 48'd0,    1'b0);
        send_item(MODE_PICK,   8'd0,   2'd0, 48'd0,    1'b0);
        send_item(MODE_ADD,    8'd7,   2'd1, 48'd100,  1'b0);
        send_item(MODE_ADD,    8'd7,   2'd2, 48'd50,   1'b0);
        send_item(MODE_SET_RT, 8'd255, 2'd0, '1,       1'b0);
        send_item(MODE_PICK,   8'd0,   2'd0, 48'd0,    1'b0);
        send_item(MODE_SET_RT, 8'd7,   2'd0, 48'd60,   1'b0);
        send_item(MODE_ADD,    8'd9,   2'd0, 48'd120,  1'b0);
        send_item(MODE_PICK,   8'd0,   2'd0, 48'd0,    1'b0);
        send_item(MODE_REMOVE, 8'd7,   2'd0, 48'd0,    1'b0);
        send_item(MODE_PICK,   8'd0,   2'd0, 48'd0,    1'b0);
        // fill to capacity, then add to a full queue
        for (int k = 0; k < 12; k++)
            send_item(MODE_ADD, 8'(16 + k), 2'(k), 48'(k * 1000), 1'b0);
        send_item(MODE_ADD,    8'hAA, 2'd1, 48'h5555_5555_5555, 1'b0);
        send_item(MODE_REMOVE, 8'd200, 2'd0, 48'd0, 1'b0);
        send_item(MODE_PICK,   8'd0,  2'd0, 48'd0, 1'b0);

        bias = 1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) bias = $urandom_range(2);
            add_pct = (bias == 0) ? 55 : (bias == 1) ? 35 : 15;
            rem_pct = (bias == 0) ? 15 : (bias == 1) ? 30 : 50;
            r = $urandom_range(99);
            if (r < add_pct)
                mode = MODE_ADD;
            else if (r < add_pct + rem_pct)
                mode = MODE_REMOVE;
            else if (r < add_pct + rem_pct + (100 - add_pct - rem_pct) / 2)
                mode = MODE_SET_RT;
            else
                mode = MODE_PICK;
            id  = ($urandom_range(99) < 80) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
            cls = 2'($urandom_range(3));
            r   = $urandom_range(99);
            if (r < 30)
                rt = 48'($urandom_range(15));
            else if (r < 35)
                rt = '0;
            else if (r < 40)
                rt = '1;
            else
                rt = {16'($urandom), 32'($urandom)};
            if (n == DRAIN_AT) drain_results();
            send_item(mode, id, cls, rt, (n / 100) % 5 == 2);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
